FILE: hw/rtl/one_wire_temperature_poller_defines.svh
// assertion macros for the one-wire temperature poller
`ifndef ONE_WIRE_TEMPERATURE_POLLER_DEFINES_SVH
`define ONE_WIRE_TEMPERATURE_POLLER_DEFINES_SVH

// condition that must hold on every clock edge out of reset
`define OWTP_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// condition that must hold whenever the trigger holds
`define OWTP_ASSERT_IMPLIES(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

`endif

FILE: hw/rtl/owtp_pkg.sv
// types and constants of the one-wire temperature poller
package owtp_pkg;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_W       = 24;
    localparam int CFG_INDEX_W = 2;
    localparam int TEMP_W      = 17;

    localparam logic [CFG_INDEX_W-1:0] CFG_POLL_PERIOD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONV_WAIT   = 2'd1;

    localparam logic [CFG_W-1:0] POLL_PERIOD_RESET = 24'd5000000;
    localparam logic [CFG_W-1:0] CONV_WAIT_RESET   = 24'd1000000;

    localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
    localparam logic [7:0] CMD_CONVERT  = 8'h44;
    localparam logic [7:0] CMD_READ_PAD = 8'hBE;

    // slot timing in microsecond ticks
    localparam logic [9:0] T_WAIT_HIGH   = 10'd250;
    localparam logic [9:0] T_RESET_LOW   = 10'd480;
    localparam logic [9:0] T_RESET_REL   = 10'd480;
    localparam logic [9:0] T_W1_LOW      = 10'd10;
    localparam logic [9:0] T_W1_SLOT     = 10'd65;
    localparam logic [9:0] T_W0_LOW      = 10'd65;
    localparam logic [9:0] T_W0_SLOT     = 10'd70;
    localparam logic [9:0] T_RD_LOW      = 10'd3;
    localparam logic [9:0] T_RD_SAMPLE   = 10'd13;
    localparam logic [9:0] T_RD_SLOT     = 10'd66;

    localparam logic [15:0] RAW_WRAP_LIMIT = 16'd16000;
    localparam logic signed [TEMP_W-1:0] NO_SENSOR_TEMP = -17'sd4400;

    // one result item, drive_low in the lowest bit
    typedef struct packed {
        logic                     bus_busy;
        logic signed [TEMP_W-1:0] temperature_sixteenths;
        logic                     temp_changed;
        logic                     drive_low;
    } result_t;

endpackage

FILE: hw/rtl/one_wire_temperature_poller.sv
// one-wire bus master that polls a single temperature sensor, one tick per transfer
//
//  channel     dir  handshake                  payload
//  s_axis      in   s_axis_tvalid/tready       line level of this tick
//  m_axis      out  m_axis_tvalid/tready       drive level, change flag, temperature, busy
//  cfg         in   cfg_we                     poll period, conversion wait
//
// one tick is accepted per clock cycle; the whole state update for a tick is one
// register-to-register pass, and the result goes to the output register or skid entry
// rst_n clears the sequencer to idle, the counters to zero and the temperature to -275 C
// a two-entry output (register plus skid) keeps s_axis_tready high while one result
// waits; ticks stop being taken only when both entries are full
`include "one_wire_temperature_poller_defines.svh"

module one_wire_temperature_poller #(
    parameter int SCRATCH_BYTES = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [owtp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [0] line_level
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] drive_low, [1] temp_changed, [18:2] temperature_sixteenths, [19] bus_busy
    output logic [owtp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                               cfg_we,
    input  logic [owtp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [owtp_pkg::CFG_W-1:0]         cfg_data
);
    import owtp_pkg::*;

    localparam int BYTE_W = (SCRATCH_BYTES > 2) ? $clog2(SCRATCH_BYTES) : 1;
    localparam logic [BYTE_W-1:0] LAST_BYTE = BYTE_W'(SCRATCH_BYTES - 1);
    localparam logic [BYTE_W-1:0] CMD_LAST  = BYTE_W'(1);
    localparam int PAD_W = OUT_TDATA_W - $bits(result_t);

    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_A_WAITHIGH = 4'd1;
    localparam logic [3:0] PH_A_LOW      = 4'd2;
    localparam logic [3:0] PH_A_RELEASE  = 4'd3;
    localparam logic [3:0] PH_A_WRITE    = 4'd4;
    localparam logic [3:0] PH_B_WAITHIGH = 4'd5;
    localparam logic [3:0] PH_B_LOW      = 4'd6;
    localparam logic [3:0] PH_B_RELEASE  = 4'd7;
    localparam logic [3:0] PH_B_WRITE    = 4'd8;
    localparam logic [3:0] PH_B_READ     = 4'd9;

    logic [CFG_W-1:0] poll_period_reg, conv_wait_reg;

    logic [3:0]        phase_reg, phase_next;
    logic [9:0]        slot_reg, slot_next;
    logic [2:0]        bit_reg, bit_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic [7:0]        shift_reg, shift_next;
    logic [15:0]       raw_reg, raw_next;
    logic              any_not_ff_reg, any_not_ff_next;
    logic [CFG_W-1:0]  period_reg, period_next;
    logic [CFG_W-1:0]  wait_reg, wait_next;
    logic              pending_reg, pending_next;
    logic signed [TEMP_W-1:0] temp_reg, temp_next;

    logic        accept;
    logic        line;
    logic        due;
    logic [CFG_W:0] period_inc, wait_inc;
    logic [9:0]  slot_inc;
    logic        second_seq;
    logic [7:0]  cmd_byte;
    logic        cmd_bit;
    logic [9:0]  low_len, slot_len;
    logic        drive;
    logic        changed;
    logic        busy;
    logic signed [TEMP_W-1:0] temp_calc;
    result_t     result;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, skid_reg;
    logic    out_load, out_from_skid, skid_load;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign line   = s_axis_tdata[0];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_period_reg <= POLL_PERIOD_RESET;
            conv_wait_reg   <= CONV_WAIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POLL_PERIOD: poll_period_reg <= cfg_data;
                CFG_CONV_WAIT:   conv_wait_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // sequencer: next state for one tick
    always_comb
    begin
        phase_next      = phase_reg;
        slot_next       = slot_reg;
        bit_next        = bit_reg;
        byte_next       = byte_reg;
        shift_next      = shift_reg;
        raw_next        = raw_reg;
        any_not_ff_next = any_not_ff_reg;
        wait_next       = wait_reg;
        pending_next    = pending_reg;
        temp_next       = temp_reg;
        drive           = 1'b0;
        changed         = 1'b0;
        temp_calc       = NO_SENSOR_TEMP;

        busy       = (phase_reg >= PH_A_WAITHIGH) && (phase_reg <= PH_B_READ);
        period_inc = {1'b0, period_reg} + 25'd1;
        wait_inc   = {1'b0, wait_reg} + 25'd1;
        due        = period_inc >= {1'b0, poll_period_reg};
        slot_inc   = slot_reg + 10'd1;

        second_seq = (phase_reg == PH_B_WRITE);
        cmd_byte   = (byte_reg == '0) ? CMD_SKIP_ROM
                                      : (second_seq ? CMD_READ_PAD : CMD_CONVERT);
        cmd_bit    = cmd_byte[bit_reg];
        low_len    = cmd_bit ? T_W1_LOW : T_W0_LOW;
        slot_len   = cmd_bit ? T_W1_SLOT : T_W0_SLOT;

        // a due poll holds the period counter until the sequence starts
        period_next = due ? period_reg : period_inc[CFG_W-1:0];

        unique case (phase_reg) inside
            PH_A_WAITHIGH, PH_B_WAITHIGH:
            begin
                if (line)
                begin
                    phase_next = phase_reg + 4'd1;
                    slot_next  = '0;
                end
                else if (slot_inc >= T_WAIT_HIGH)
                begin
                    // line never came up: skip the reset pulse
                    phase_next = phase_reg + 4'd3;
                    slot_next  = '0;
                    bit_next   = '0;
                    byte_next  = '0;
                end
                else
                begin
                    slot_next = slot_inc;
                end
            end
            PH_A_LOW, PH_B_LOW:
            begin
                drive = 1'b1;
                if (slot_inc >= T_RESET_LOW)
                begin
                    phase_next = phase_reg + 4'd1;
                    slot_next  = '0;
                end
                else
                begin
                    slot_next = slot_inc;
                end
            end
            PH_A_RELEASE, PH_B_RELEASE:
            begin
                if (slot_inc >= T_RESET_REL)
                begin
                    phase_next = phase_reg + 4'd1;
                    slot_next  = '0;
                    bit_next   = '0;
                    byte_next  = '0;
                end
                else
                begin
                    slot_next = slot_inc;
                end
            end
            PH_A_WRITE, PH_B_WRITE:
            begin
                drive = slot_reg < low_len;
                if (slot_inc >= slot_len)
                begin
                    slot_next = '0;
                    if (bit_reg == 3'd7)
                    begin
                        bit_next = '0;
                        if (byte_reg == CMD_LAST)
                        begin
                            byte_next = '0;
                            if (second_seq)
                            begin
                                phase_next      = PH_B_READ;
                                shift_next      = '0;
                                raw_next        = '0;
                                any_not_ff_next = 1'b0;
                            end
                            else
                            begin
                                phase_next   = PH_IDLE;
                                pending_next = 1'b1;
                                wait_next    = '0;
                            end
                        end
                        else
                        begin
                            byte_next = byte_reg + BYTE_W'(1);
                        end
                    end
                    else
                    begin
                        bit_next = bit_reg + 3'd1;
                    end
                end
                else
                begin
                    slot_next = slot_inc;
                end
            end
            PH_B_READ:
            begin
                drive = slot_reg < T_RD_LOW;
                if (slot_reg == T_RD_SAMPLE)
                    shift_next = {line, shift_reg[7:1]};
                if (slot_inc >= T_RD_SLOT)
                begin
                    slot_next = '0;
                    if (bit_reg == 3'd7)
                    begin
                        bit_next = '0;
                        any_not_ff_next = any_not_ff_reg || (shift_reg != 8'hFF);
                        if (byte_reg == BYTE_W'(0))
                            raw_next = {raw_reg[15:8], shift_reg};
                        else if (byte_reg == BYTE_W'(1))
                            raw_next = {shift_reg, raw_reg[7:0]};
                        if (byte_reg == LAST_BYTE)
                        begin
                            // all bytes 0xff means nobody answered
                            if (!any_not_ff_next)
                                temp_calc = NO_SENSOR_TEMP;
                            else if (raw_next > RAW_WRAP_LIMIT)
                                temp_calc = {1'b1, raw_next};
                            else
                                temp_calc = {1'b0, raw_next};
                            if (temp_calc != temp_reg)
                            begin
                                temp_next = temp_calc;
                                changed   = 1'b1;
                            end
                            byte_next  = '0;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            byte_next = byte_reg + BYTE_W'(1);
                        end
                    end
                    else
                    begin
                        bit_next = bit_reg + 3'd1;
                    end
                end
                else
                begin
                    slot_next = slot_inc;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (due)
                begin
                    // a due poll cancels any pending read
                    period_next  = '0;
                    pending_next = 1'b0;
                    phase_next   = PH_A_WAITHIGH;
                    slot_next    = '0;
                    bit_next     = '0;
                    byte_next    = '0;
                end
                else if (pending_reg)
                begin
                    if (wait_inc >= {1'b0, conv_wait_reg})
                    begin
                        pending_next = 1'b0;
                        wait_next    = '0;
                        phase_next   = PH_B_WAITHIGH;
                        slot_next    = '0;
                        bit_next     = '0;
                        byte_next    = '0;
                    end
                    else
                    begin
                        wait_next = wait_inc[CFG_W-1:0];
                    end
                end
            end
        endcase

        result.drive_low              = drive;
        result.temp_changed           = changed;
        result.temperature_sixteenths = temp_next;
        result.bus_busy               = busy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            slot_reg       <= '0;
            bit_reg        <= '0;
            byte_reg       <= '0;
            shift_reg      <= '0;
            raw_reg        <= '0;
            any_not_ff_reg <= 1'b0;
            period_reg     <= '0;
            wait_reg       <= '0;
            pending_reg    <= 1'b0;
            temp_reg       <= NO_SENSOR_TEMP;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            slot_reg       <= slot_next;
            bit_reg        <= bit_next;
            byte_reg       <= byte_next;
            shift_reg      <= shift_next;
            raw_reg        <= raw_next;
            any_not_ff_reg <= any_not_ff_next;
            period_reg     <= period_next;
            wait_reg       <= wait_next;
            pending_reg    <= pending_next;
            temp_reg       <= temp_next;
        end
    end

    // output register with skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_load        = 1'b0;
        out_from_skid   = 1'b0;
        skid_load       = 1'b0;
        if (accept)
        begin
            if (!out_valid_reg || m_axis_tready)
            begin
                out_load       = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_load       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_valid_reg && m_axis_tready)
        begin
            if (skid_valid_reg)
            begin
                out_from_skid   = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= result;
        else if (out_from_skid)
            out_reg <= skid_reg;
        if (skid_load)
            skid_reg <= result;
    end

    assign s_axis_tready = !skid_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_reg};

    `OWTP_ASSERT_IMPLIES(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg,
        "skid entry holds a transfer while the output register is empty")
    `OWTP_ASSERT_ALWAYS(a_slot_in_range, clk, rst_n, slot_reg < T_RESET_LOW,
        "slot timer ran past the longest slot")
    `OWTP_ASSERT_IMPLIES(a_pending_only_idle, clk, rst_n, pending_reg, phase_reg == PH_IDLE,
        "read pending outside idle phase")

endmodule
